/* sv/constant_rate_cell_shaper_top_assert.svh */
`ifndef CONSTANT_RATE_CELL_SHAPER_TOP_ASSERT_SVH
`define CONSTANT_RATE_CELL_SHAPER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// Next-cycle implication, checked outside reset.
`define CRCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

/* sv/crcs_pkg.sv */
package crcs_pkg;

	localparam int unsigned ChunkMin   = 64;
	localparam int unsigned ChunkMax   = 1500;
	localparam int unsigned ChunkReset = 800;
	localparam int unsigned MaxPacket  = 1500;

	typedef enum logic [1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DROP = 2'd1,
		KIND_DATA = 2'd2,
		KIND_PAD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// One descriptor slot. A remaining count of zero means the slot is free.
	typedef struct packed {
		logic [10:0] rem;
		logic [15:0] seq;
		logic [10:0] sent;
		logic [4:0]  frag;
	} entry_t;

endpackage

/* sv/crcs_slot_mem.sv */
module crcs_slot_mem #(
	parameter int SLOTS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       re,
	input  logic [$clog2(SLOTS)-1:0]   raddr,
	output crcs_pkg::entry_t           rdata,
	input  logic                       we,
	input  logic [$clog2(SLOTS)-1:0]   waddr,
	input  crcs_pkg::entry_t           wdata
);
	import crcs_pkg::*;

	entry_t mem [SLOTS];
	logic [SLOTS-1:0] written_q;
	entry_t rd_data_q;
	logic rd_ok_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	// Per-slot written flags let a never-written slot read as free without a clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_ok_q <= written_q[raddr];
			end
		end
	end

	always_comb begin
		rdata = rd_data_q;
		if (!rd_ok_q) begin
			rdata.rem = '0;
		end
	end

endmodule

/* sv/constant_rate_cell_shaper_top.sv */
// Each request is accepted in idle, then every slot is read once from the descriptor memory.
// Requests stall through the scan, the drain state and the result load, and a new one is
// accepted only back in idle; an output stall holds the result load back.
// Reset: asynchronous, active low; all slots free, sequence zero, chunk size 800.
// Slot occupancy flags clear at once on reset, so no memory clearing pass is needed.
`include "constant_rate_cell_shaper_top_assert.svh"

module constant_rate_cell_shaper_top #(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] chunk_size,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [10:0] pkt_len,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  result_kind,
	output logic [4:0]  slot,
	output logic [10:0] chunk_offset,
	output logic [10:0] chunk_len,
	output logic [4:0]  fragment_index,
	output logic        last_chunk
);
	import crcs_pkg::*;

	localparam int IW = $clog2(SLOTS);

	state_t state_q, state_d;
	logic [10:0] chunk_size_q;
	logic [15:0] next_seq_q;
	logic req_type_q;
	logic [10:0] pkt_len_q;
	logic [IW-1:0] scan_q;
	logic scan_s1;
	logic [IW-1:0] idx_s1;
	logic hit_q;
	logic [IW-1:0] best_idx_q;
	entry_t best_q;
	entry_t rd_entry;

	logic accept;
	logic rd_en;
	logic load;
	logic wr_en;
	entry_t wr_entry;
	logic [1:0] kind_d;
	logic [10:0] off_d, len_d;
	logic [4:0] frag_d;
	logic last_d;
	logic [10:0] csz;
	logic [10:0] len_cl;

	logic res_valid_q;
	logic [1:0] kind_q;
	logic [4:0] slot_q;
	logic [10:0] off_q, len_q;
	logic [4:0] frag_q;
	logic last_q;

	assign cfg_ready = 1'b1;
	assign accept = req_valid && !req_stall;

	crcs_slot_mem #(.SLOTS(SLOTS)) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.re    (rd_en),
		.raddr (scan_q),
		.rdata (rd_entry),
		.we    (wr_en),
		.waddr (best_idx_q),
		.wdata (wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_stall = 1'b1;
		rd_en = 1'b0;
		load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_q == IW'(SLOTS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!res_valid_q || !res_stall) begin
					load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= 11'(ChunkReset);
			next_seq_q <= '0;
			scan_q <= '0;
			scan_s1 <= 1'b0;
			hit_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				chunk_size_q <= chunk_size;
			end
			scan_s1 <= rd_en;
			if (accept) begin
				scan_q <= '0;
				hit_q <= 1'b0;
			end else if (rd_en && scan_q != IW'(SLOTS - 1)) begin
				scan_q <= scan_q + 1'b1;
			end
			if (scan_s1) begin
				if (!req_type_q) begin
					if (!hit_q && rd_entry.rem == '0) begin
						hit_q <= 1'b1;
					end
				end else if (rd_entry.rem != '0 && (!hit_q || rd_entry.seq < best_q.seq)) begin
					hit_q <= 1'b1;
				end
			end
			if (load && !req_type_q && hit_q) begin
				next_seq_q <= next_seq_q + 1'b1;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			pkt_len_q <= pkt_len;
		end
		idx_s1 <= scan_q;
		if (scan_s1) begin
			if (!req_type_q) begin
				if (!hit_q && rd_entry.rem == '0) begin
					best_idx_q <= idx_s1;
				end
			end else if (rd_entry.rem != '0 && (!hit_q || rd_entry.seq < best_q.seq)) begin
				best_idx_q <= idx_s1;
				best_q <= rd_entry;
			end
		end
		if (load) begin
			kind_q <= kind_d;
			slot_q <= hit_q ? 5'(best_idx_q) : 5'd0;
			off_q <= off_d;
			len_q <= len_d;
			frag_q <= frag_d;
			last_q <= last_d;
		end
	end

	always_comb begin
		csz = chunk_size_q;
		if (32'(chunk_size_q) < ChunkMin) begin
			csz = 11'(ChunkMin);
		end else if (32'(chunk_size_q) > ChunkMax) begin
			csz = 11'(ChunkMax);
		end
		len_cl = (32'(pkt_len_q) > MaxPacket) ? 11'(MaxPacket) : pkt_len_q;

		wr_entry = best_q;
		off_d = '0;
		len_d = '0;
		frag_d = '0;
		last_d = 1'b0;
		if (!req_type_q) begin
			kind_d = hit_q ? KIND_ENQ : KIND_DROP;
			wr_entry.rem = len_cl;
			wr_entry.seq = next_seq_q;
			wr_entry.sent = '0;
			wr_entry.frag = '0;
		end else begin
			kind_d = hit_q ? KIND_DATA : KIND_PAD;
			if (hit_q) begin
				off_d = best_q.sent;
				frag_d = best_q.frag;
				if (best_q.rem > csz) begin
					len_d = csz;
					wr_entry.rem = best_q.rem - csz;
					wr_entry.frag = best_q.frag + 1'b1;
				end else begin
					len_d = best_q.rem;
					wr_entry.rem = '0;
					last_d = 1'b1;
				end
				wr_entry.sent = best_q.sent + len_d;
			end
		end
		wr_en = load && hit_q;
	end

	assign res_valid = res_valid_q;
	assign result_kind = kind_q;
	assign slot = slot_q;
	assign chunk_offset = off_q;
	assign chunk_len = len_q;
	assign fragment_index = frag_q;
	assign last_chunk = last_q;

	`CRCS_ASSERT_NXT(a_accept_starts_scan, clk, arst_n, accept, state_q == ST_SCAN)
	`CRCS_ASSERT_IMP(a_write_only_at_finish, clk, arst_n, wr_en, state_q == ST_FIN && load)
	`CRCS_ASSERT_IMP(a_pad_is_empty, clk, arst_n, res_valid && result_kind == KIND_PAD,
		chunk_len == '0 && slot == '0 && !last_chunk)
	`CRCS_ASSERT_IMP(a_data_len_bounded, clk, arst_n, res_valid && result_kind == KIND_DATA,
		chunk_len != '0 && 32'(chunk_len) <= ChunkMax)

endmodule

/* tb/testbench.sv */
module testbench;
	import crcs_pkg::*;

	localparam int SlotCount = 32;
	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned DrainCycles = 2 * (SlotCount + 2) + 10;
	localparam int unsigned HoldCycles = 600;
	localparam int unsigned ItemsPerSetting = 190;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  slot_no;
		logic [10:0] offset;
		logic [10:0] bytes;
		logic [4:0]  frag;
		logic        last;
	} cell_t;

	typedef struct packed {
		logic        tick;
		logic [10:0] len;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] chunk_size = 11'(ChunkReset);
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        req_type = 1'b0;
	logic [10:0] pkt_len = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [4:0]  slot;
	logic [10:0] chunk_offset;
	logic [10:0] chunk_len;
	logic [4:0]  fragment_index;
	logic        last_chunk;

	// Shadow copy of the descriptor queue.
	logic [10:0] q_remaining [SlotCount];
	logic [15:0] q_stamp [SlotCount];
	logic [10:0] q_sent [SlotCount];
	logic [4:0]  q_frags [SlotCount];
	logic [15:0] stamp_next;
	logic [10:0] cell_bytes;

	request_t requests_to_send [$];
	cell_t    cells_due [$];

	int unsigned sent_count = 0;
	int unsigned mismatches = 0;
	int unsigned settings_used = 0;
	int unsigned holds_done = 0;
	int unsigned kind_seen [4] = '{0, 0, 0, 0};
	int unsigned last_seen = 0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 1;
	int unsigned rx_left = 0;
	int unsigned rx_mode = 0;
	logic        link_hold = 1'b0;

	constant_rate_cell_shaper_top #(
		.SLOTS(SlotCount)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.chunk_size    (chunk_size),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.pkt_len       (pkt_len),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.result_kind   (result_kind),
		.slot          (slot),
		.chunk_offset  (chunk_offset),
		.chunk_len     (chunk_len),
		.fragment_index(fragment_index),
		.last_chunk    (last_chunk)
	);

	always #5 clk = ~clk;

	// Out-of-range settings are clamped to the legal cell payload.
	function automatic logic [10:0] cell_payload(input logic [10:0] setting);
		if (setting < 11'(ChunkMin))
			return 11'(ChunkMin);
		if (setting > 11'(ChunkMax))
			return 11'(ChunkMax);
		return setting;
	endfunction

	function automatic cell_t shape_request(input logic is_tick, input logic [10:0] len);
		cell_t r;
		int pick;
		int i;
		logic [10:0] csz;
		r = '0;
		pick = -1;
		if (!is_tick) begin
			for (i = 0; i < SlotCount; i++)
				if (pick < 0 && q_remaining[i] == 0)
					pick = i;
			if (pick < 0) begin
				r.kind = KIND_DROP;
			end else begin
				q_stamp[pick] = stamp_next;
				stamp_next = stamp_next + 16'd1;
				q_frags[pick] = '0;
				q_sent[pick] = '0;
				q_remaining[pick] = (len > 11'(MaxPacket)) ? 11'(MaxPacket) : len;
				r.kind = KIND_ENQ;
				r.slot_no = 5'(pick);
			end
		end else begin
			// Oldest stamp wins; the strict compare leaves ties with the lowest slot.
			for (i = 0; i < SlotCount; i++)
				if (q_remaining[i] != 0 && (pick < 0 || q_stamp[i] < q_stamp[pick]))
					pick = i;
			if (pick < 0) begin
				r.kind = KIND_PAD;
			end else begin
				csz = cell_payload(cell_bytes);
				r.kind = KIND_DATA;
				r.slot_no = 5'(pick);
				r.offset = q_sent[pick];
				r.frag = q_frags[pick];
				if (q_remaining[pick] > csz) begin
					r.bytes = csz;
					q_remaining[pick] = q_remaining[pick] - csz;
					q_sent[pick] = q_sent[pick] + csz;
					q_frags[pick] = q_frags[pick] + 5'd1;
				end else begin
					r.bytes = q_remaining[pick];
					q_sent[pick] = q_sent[pick] + q_remaining[pick];
					q_remaining[pick] = '0;
					r.last = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [10:0] pick_length();
		int unsigned sel;
		int unsigned csz;
		sel = $urandom_range(0, 19);
		csz = cell_payload(cell_bytes);
		case (sel)
			0, 1: return '0;
			2: return 11'($urandom_range(MaxPacket + 1, 2047));
			3: return 11'(MaxPacket);
			4: return 11'(csz * $urandom_range(1, MaxPacket / csz));
			5, 6, 7, 8, 9: return 11'($urandom_range(1, 64));
			default: return 11'($urandom_range(1, MaxPacket));
		endcase
	endfunction

	task automatic push_req(input logic tick, input logic [10:0] len);
		request_t q;
		q.tick = tick;
		q.len = len;
		requests_to_send.push_back(q);
	endtask

	// Mostly runs of enqueues and runs of ticks, so the queue both fills and drains.
	task automatic queue_random(input int unsigned count);
		int unsigned made;
		int unsigned n;
		int unsigned flavor;
		int unsigned i;
		made = 0;
		while (made < count) begin
			flavor = $urandom_range(0, 9);
			n = $urandom_range(1, (flavor >= 4 && flavor <= 6) ? 80 : 40);
			for (i = 0; i < n; i++) begin
				case (flavor)
					0, 1, 2, 3: begin
						if ($urandom_range(0, 7) == 0)
							push_req(1'b1, 11'($urandom));
						else
							push_req(1'b0, pick_length());
					end
					4, 5, 6: push_req(1'b1, 11'($urandom));
					7, 8: begin
						if ($urandom_range(0, 1))
							push_req(1'b1, 11'($urandom));
						else
							push_req(1'b0, pick_length());
					end
					default: push_req(1'($urandom), 11'($urandom));
				endcase
			end
			made += n;
		end
	endtask

	task automatic wait_idle();
		while (requests_to_send.size() != 0 || req_valid || cells_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_chunk_size(input logic [10:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		chunk_size <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cell_bytes = value;
		settings_used++;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Sender: bursts of requests separated by random gaps.
	always @(posedge clk) begin : sender
		request_t nxt;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				cells_due.push_back(shape_request(req_type, pkt_len));
				sent_count++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (requests_to_send.size() > 0) begin
					nxt = requests_to_send.pop_front();
					req_valid <= 1'b1;
					req_type <= nxt.tick;
					pkt_len <= nxt.len;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 45);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall density changes from one stretch to the next.
	always @(posedge clk) begin : receiver
		logic busy;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0: busy = 1'b0;
			1: busy = ($urandom_range(0, 3) == 0);
			2: busy = 1'($urandom_range(0, 1));
			default: busy = ($urandom_range(0, 3) != 0);
		endcase
		res_stall <= link_hold || busy;
	end

	// Long output hold-offs so the block backs up into its request side.
	initial begin : hold_off
		int unsigned marks [2];
		int k;
		marks = '{400, 1100};
		for (k = 0; k < 2; k++) begin
			wait (sent_count >= marks[k]);
			@(posedge clk);
			link_hold <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			link_hold <= 1'b0;
			holds_done++;
		end
	end

	always @(posedge clk) begin : monitor
		cell_t want;
		if (arst_n && res_valid && !res_stall) begin
			kind_seen[result_kind]++;
			if (result_kind == KIND_DATA && last_chunk)
				last_seen++;
			if (cells_due.size() == 0) begin
				$error("result with no request outstanding: result_kind %0d slot %0d",
					result_kind, slot);
				mismatches++;
			end else begin
				want = cells_due.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("slot", want.slot_no, slot);
				check_field("chunk_offset", want.offset, chunk_offset);
				check_field("chunk_len", want.bytes, chunk_len);
				check_field("fragment_index", want.frag, fragment_index);
				check_field("last_chunk", want.last, last_chunk);
			end
		end
	end

	initial begin : watchdog
		int unsigned elapsed;
		elapsed = 0;
		while (elapsed < CycleLimit) begin
			@(posedge clk);
			elapsed++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", elapsed,
			cells_due.size());
		$display("constant_rate_cell_shaper_top test failed");
		$finish;
	end

	initial begin : stimulus
		logic [10:0] settings [8];
		int i;
		for (i = 0; i < SlotCount; i++) begin
			q_remaining[i] = '0;
			q_stamp[i] = '0;
			q_sent[i] = '0;
			q_frags[i] = '0;
		end
		stamp_next = '0;
		cell_bytes = 11'(ChunkReset);
		settings = '{11'd64, 11'd1500, 11'd0, 11'd2047, 11'd63, 11'd1501, 11'd0, 11'd800};
		settings[6] = 11'($urandom_range(ChunkMin + 1, ChunkMax - 1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset chunk size of 800.
		push_req(1'b1, 11'd0);
		push_req(1'b0, 11'd0);
		push_req(1'b0, 11'd2047);
		push_req(1'b0, 11'd1500);
		push_req(1'b0, 11'd1);
		push_req(1'b0, 11'd800);
		push_req(1'b0, 11'd801);
		push_req(1'b0, 11'd64);
		for (i = 0; i < 9; i++)
			push_req(1'b1, 11'(i));
		push_req(1'b1, 11'd2047);
		wait_idle();

		for (i = 0; i < 8; i++) begin
			write_chunk_size(settings[i]);
			queue_random(ItemsPerSetting);
			wait_idle();
		end

		repeat (DrainCycles) @(posedge clk);
		$display("Covered %0d requests over %0d chunk size settings with %0d long hold-offs.",
			sent_count, settings_used, holds_done);
		$display("Results: %0d enqueued, %0d dropped, %0d data (%0d final), %0d padding.",
			kind_seen[KIND_ENQ], kind_seen[KIND_DROP], kind_seen[KIND_DATA], last_seen,
			kind_seen[KIND_PAD]);
		if (mismatches == 0 && cells_due.size() == 0)
			$display("constant_rate_cell_shaper_top test passed");
		else
			$display("constant_rate_cell_shaper_top test failed");
		$finish;
	end

endmodule

/* constant_rate_cell_shaper_top.f */
+incdir+sv
sv/crcs_pkg.sv
sv/crcs_slot_mem.sv
sv/constant_rate_cell_shaper_top.sv
tb/testbench.sv
